// ===== rtl/nbe_pkg.sv =====
package nbe_pkg;

  // Item function codes.
  typedef enum logic [2:0] {
    FN_NAME      = 3'd0,
    FN_TYPE      = 3'd1,
    FN_SCOPE     = 3'd2,
    FN_END_SCOPE = 3'd3,
    FN_FINISH    = 3'd4
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_NAME,
    ST_FLEN,
    ST_FCHR,
    ST_FIN
  } state_t;

  // Character constants.
  localparam logic [7:0] ENC_BASE  = 8'h41;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } res_t;

endpackage

// ===== rtl/nbe_in_if.sv =====
interface nbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] data_byte;
  logic       upper_case;

  modport source (output valid, output func, output data_byte, output upper_case,
                  input ready);
  modport sink (input valid, input func, input data_byte, input upper_case,
                output ready);
endinterface

// ===== rtl/nbe_out_if.sv =====
interface nbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/nbe_label_mem.sv =====
module nbe_label_mem #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data_r
);

  logic [7:0] mem [2**AW];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== rtl/nbe_out_reg.sv =====
module nbe_out_reg
  import nbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       ld,
  input  res_t       res,
  output logic       free,
  output logic       valid,
  input  logic       ready,
  output logic [7:0] out_byte,
  output logic       last
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // The register can take a new item when empty or when its item leaves now.
  assign free = !valid_r || ready;

  always_comb begin
    if (ld) begin
      valid_nxt = 1'b1;
    end else if (ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res_r <= res;
    end
  end

  assign valid    = valid_r;
  assign out_byte = res_r.out_byte;
  assign last     = res_r.last;

endmodule

// ===== rtl/nbe_ctrl.sv =====
module nbe_ctrl
  import nbe_pkg::*;
#(
  parameter int NAME_LEN  = 16,
  parameter int MAX_LABEL = 63,
  parameter int AW        = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_func,
  input  logic [7:0]    in_data,
  input  logic          in_upper,
  input  logic          res_free,
  output logic          res_ld,
  output res_t          res,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata
);

  localparam int CW = $clog2(NAME_LEN + 1);
  localparam int PW = $clog2(NAME_LEN);
  localparam int LW = $clog2(MAX_LABEL + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] name_count_r, name_count_nxt;
  logic [7:0]    held_first_r, held_first_nxt;
  logic [LW-1:0] label_len_r, label_len_nxt;
  logic [LW-1:0] flen_r, flen_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] end_r, end_nxt;
  logic          half_r, half_nxt;
  logic          wild_r, wild_nxt;
  logic          use_held_r, use_held_nxt;
  logic          name_go_r, name_go_nxt;
  logic [7:0]    data_r, data_nxt;

  logic       adv;
  logic       step_done;
  logic       accept;
  logic [7:0] name_byte;
  logic [7:0] d_uc;
  logic       closed;

  assign closed = (name_count_r == CW'(NAME_LEN));
  assign accept = in_valid && in_ready;

  // Upper-case conversion of a name character.
  assign d_uc = (in_upper && (in_data inside {[CH_LC_A:CH_LC_Z]})) ? (in_data - CASE_DIFF)
                                                                    : in_data;

  // Name byte at the current position of the name sequence.
  always_comb begin
    if (wild_r) begin
      name_byte = (pos_r == '0) ? CH_STAR : 8'h00;
    end else if (use_held_r && (pos_r == '0)) begin
      name_byte = held_first_r;
    end else if (pos_r == end_r) begin
      name_byte = data_r;
    end else begin
      name_byte = CH_SPACE;
    end
  end

  // Output byte of the current state and whether it ends the item's work.
  always_comb begin
    res       = '{out_byte: 8'h00, last: 1'b0};
    step_done = 1'b0;
    case (state_r)
      ST_LEN: begin
        res.out_byte = 8'(2 * NAME_LEN);
        step_done    = !name_go_r;
      end
      ST_NAME: begin
        res.out_byte = half_r ? (ENC_BASE + {4'h0, name_byte[3:0]})
                              : (ENC_BASE + {4'h0, name_byte[7:4]});
        step_done    = half_r && (pos_r == end_r);
      end
      ST_FLEN: begin
        res.out_byte = 8'(flen_r);
        step_done    = (flen_r == '0);
      end
      ST_FCHR: begin
        res.out_byte = mem_rdata;
        step_done    = (idx_r == (flen_r - LW'(1)));
      end
      ST_FIN: begin
        res.last  = 1'b1;
        step_done = 1'b1;
      end
      default: begin
        step_done = 1'b0;
      end
    endcase
    res_ld   = (state_r != ST_IDLE) && res_free;
    adv      = res_ld;
    in_ready = (state_r == ST_IDLE) || (adv && step_done);
  end

  // Label memory read address, one ahead while characters move out.
  always_comb begin
    if ((state_r == ST_FCHR) && adv) begin
      mem_raddr = AW'(idx_r + LW'(1));
    end else begin
      mem_raddr = idx_r[AW-1:0];
    end
  end

  // Next state: step through the current sequence, then decode a new item.
  always_comb begin
    state_nxt      = state_r;
    name_count_nxt = name_count_r;
    held_first_nxt = held_first_r;
    label_len_nxt  = label_len_r;
    flen_nxt       = flen_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    end_nxt        = end_r;
    half_nxt       = half_r;
    wild_nxt       = wild_r;
    use_held_nxt   = use_held_r;
    name_go_nxt    = name_go_r;
    data_nxt       = data_r;
    mem_we         = 1'b0;
    mem_waddr      = label_len_r[AW-1:0];
    mem_wdata      = in_data;

    if (adv) begin
      case (state_r)
        ST_LEN: begin
          state_nxt = name_go_r ? ST_NAME : ST_IDLE;
        end
        ST_NAME: begin
          half_nxt = !half_r;
          if (half_r) begin
            if (pos_r == end_r) begin
              state_nxt = ST_IDLE;
            end else begin
              pos_nxt = pos_r + PW'(1);
            end
          end
        end
        ST_FLEN: begin
          state_nxt = (flen_r == '0) ? ST_IDLE : ST_FCHR;
        end
        ST_FCHR: begin
          if (step_done) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + LW'(1);
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end

    if (accept) begin
      case (func_t'(in_func))
        FN_NAME: begin
          if (name_count_r < CW'(NAME_LEN - 1)) begin
            name_count_nxt = name_count_r + CW'(1);
            half_nxt       = 1'b0;
            wild_nxt       = 1'b0;
            data_nxt       = d_uc;
            end_nxt        = name_count_r[PW-1:0];
            use_held_nxt   = (name_count_r == CW'(1));
            pos_nxt        = (name_count_r == CW'(1)) ? '0 : name_count_r[PW-1:0];
            if (name_count_r == '0) begin
              held_first_nxt = d_uc;
              name_go_nxt    = 1'b0;
              state_nxt      = ST_LEN;
            end else begin
              state_nxt = ST_NAME;
            end
          end
        end
        FN_TYPE: begin
          if (name_count_r < CW'(NAME_LEN)) begin
            name_count_nxt = CW'(NAME_LEN);
            half_nxt       = 1'b0;
            data_nxt       = in_data;
            end_nxt        = PW'(NAME_LEN - 1);
            use_held_nxt   = (name_count_r == CW'(1));
            wild_nxt       = (name_count_r == CW'(1)) && (held_first_r == CH_STAR);
            pos_nxt        = (name_count_r <= CW'(1)) ? '0 : name_count_r[PW-1:0];
            name_go_nxt    = 1'b1;
            state_nxt      = (name_count_r == '0) ? ST_LEN : ST_NAME;
          end
        end
        FN_SCOPE: begin
          if (closed) begin
            if (in_data == CH_DOT) begin
              flen_nxt      = label_len_r;
              label_len_nxt = '0;
              idx_nxt       = '0;
              state_nxt     = ST_FLEN;
            end else if (label_len_r < LW'(MAX_LABEL)) begin
              mem_we        = 1'b1;
              label_len_nxt = label_len_r + LW'(1);
            end
          end
        end
        FN_END_SCOPE: begin
          if (closed) begin
            flen_nxt      = label_len_r;
            label_len_nxt = '0;
            idx_nxt       = '0;
            state_nxt     = ST_FLEN;
          end
        end
        FN_FINISH: begin
          name_count_nxt = '0;
          held_first_nxt = 8'h00;
          label_len_nxt  = '0;
          state_nxt      = ST_FIN;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      name_count_r <= '0;
      held_first_r <= 8'h00;
      label_len_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      name_count_r <= name_count_nxt;
      held_first_r <= held_first_nxt;
      label_len_r  <= label_len_nxt;
    end
  end

  // Sequence registers, only meaningful while a sequence runs.
  always_ff @(posedge clk) begin
    flen_r     <= flen_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    end_r      <= end_nxt;
    half_r     <= half_nxt;
    wild_r     <= wild_nxt;
    use_held_r <= use_held_nxt;
    name_go_r  <= name_go_nxt;
    data_r     <= data_nxt;
  end

endmodule

// ===== rtl/netbios_name_encoder_top.sv =====
// Channel   Direction  Payload
// in_ch     sink       func[2:0], data_byte[7:0], upper_case
// out_ch    source     out_byte[7:0], last
//
// Result bytes pass through the single output register:
// a name character gives two bytes (one for the first, four for the second),
// a type item up to 1 + 2*NAME_LEN, a label flush 1 + label length and a
// stored scope character none. Label characters come from a registered label
// memory read. The next item is taken in the cycle its predecessor's last
// byte enters the output register. Reset is synchronous and clears control
// state; out_ch stalls hold the sequence in place.
module netbios_name_encoder_top
  import nbe_pkg::*;
#(
  parameter int NAME_LEN  = 16,
  parameter int MAX_LABEL = 63
) (
  input logic       clk,
  input logic       rst_n,
  nbe_in_if.sink    in_ch,
  nbe_out_if.source out_ch
);

  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  logic          res_ld;
  logic          res_free;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // Sequencer and record state.
  nbe_ctrl #(
    .NAME_LEN  (NAME_LEN),
    .MAX_LABEL (MAX_LABEL),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_func   (in_ch.func),
    .in_data   (in_ch.data_byte),
    .in_upper  (in_ch.upper_case),
    .res_free  (res_free),
    .res_ld    (res_ld),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Scope label characters.
  nbe_label_mem #(
    .AW (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_addr   (mem_raddr),
    .rd_data_r (mem_rdata)
  );

  // Output register.
  nbe_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (res_ld),
    .res      (res),
    .free     (res_free),
    .valid    (out_ch.valid),
    .ready    (out_ch.ready),
    .out_byte (out_ch.out_byte),
    .last     (out_ch.last)
  );

  // The sequencer never overwrites an item still waiting in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_ld |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten");

  // The record end marker is always a zero byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> (out_ch.out_byte == 8'h00))
    else $error("record end byte is not zero");

  // A loaded item shows up as valid in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_ld |=> out_ch.valid)
    else $error("loaded item not presented");

endmodule
